### design/sliding_window_accel_features_defines.svh
// assertion macros for the sliding window accelerometer feature block
`ifndef SLIDING_WINDOW_ACCEL_FEATURES_DEFINES_SVH
`define SLIDING_WINDOW_ACCEL_FEATURES_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define SWAF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, checked out of reset
`define SWAF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SWAF_ASSERT_IMP(lbl, ante, cons)
`define SWAF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### design/swaf_pkg.sv
// shared types and constants of the sliding window accelerometer feature block
package swaf_pkg;

    localparam int AXIS_W      = 2;
    localparam int SAMPLE_W    = 16;
    localparam int VAR_W       = 32;
    localparam int RMS_W       = 16;
    localparam int AMP_W       = 16;
    localparam int SQRT_STEPS  = 16;
    localparam int SQRT_CNT_W  = 4;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_WAIT_DE,
        ST_APPLY,
        ST_GO_NSQ,
        ST_WAIT_NSQ,
        ST_GO_SUM2,
        ST_WAIT_SUM2,
        ST_GO_VAR,
        ST_WAIT_VAR,
        ST_GO_MSQ,
        ST_WAIT_MSQ,
        ST_SQRT,
        ST_DONE
    } state_t;

endpackage

### design/swaf_ram.sv
// generic single-port ram with registered read
module swaf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 450
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### design/swaf_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
module swaf_mul #(
    parameter int A_W = 39,
    parameter int B_W = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               done,
    output logic [A_W+B_W-1:0] prod
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [P_W-1:0]   mcand_reg, mcand_next;
    logic [B_W-1:0]   mplier_reg, mplier_next;
    logic [P_W-1:0]   acc_reg, acc_next;
    logic             last;

    assign last = (cnt_reg == CNT_W'(B_W - 1));

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            mcand_next  = {{B_W{1'b0}}, a};
            mplier_next = b;
            acc_next    = '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[P_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[B_W-1:1]};
            cnt_next    = cnt_reg + CNT_W'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

### design/swaf_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module swaf_div #(
    parameter int DW = 48,
    parameter int VW = 15
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CNT_W = $clog2(DW);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    dvd_reg, dvd_next;
    logic [DW-1:0]    quo_reg, quo_next;
    logic [VW-1:0]    dvs_reg, dvs_next;
    logic [VW-1:0]    rem_reg, rem_next;
    logic [VW:0]      trial;
    logic [VW:0]      diff;
    logic             ge;

    assign trial = {rem_reg, dvd_reg[DW-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[VW-1:0] : trial[VW-1:0];
            quo_next = {quo_reg[DW-2:0], ge};
            dvd_next = {dvd_reg[DW-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### design/sliding_window_accel_features.sv
// top level of the sliding window accelerometer feature block
// usage notes
// - input channel: in_valid / in_ready with axis and sample; one transaction is one
//   signed 16-bit sample for one axis (0 x, 1 y, 2 z)
// - output channel: out_valid / out_ready with axis_out, variance, rms, amplitude;
//   exactly one output transaction per input transaction, in order
// - the block works on one sample at a time; in_ready is high only when it is idle
// - for a valid axis the time taken per sample is set by the bit-serial multiplier
//   (three products) and divider (two quotients) plus a 16-step square root; a
//   further sample is taken only once the previous result is in the output register
// - the min/max scan of the window reads WINDOW ram words and runs alongside
//   the arithmetic on the single ram port
// - an axis of AXES or more touches no state and goes straight to the final step;
//   its answer is loaded into the output register with all feature fields zero
// - after reset a clearing pass writes zero to all AXES*WINDOW window words, one per
//   cycle; in_ready stays low until it ends
// - the result sits in an output register; a stalled receiver holds the block in its
//   final step until the transaction completes
`include "sliding_window_accel_features_defines.svh"
module sliding_window_accel_features #(
    parameter int WINDOW = 150,
    parameter int AXES   = 3
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [swaf_pkg::AXIS_W-1:0]        axis,
    input  logic signed [swaf_pkg::SAMPLE_W-1:0] sample,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [swaf_pkg::AXIS_W-1:0]        axis_out,
    output logic [swaf_pkg::VAR_W-1:0]         variance,
    output logic [swaf_pkg::RMS_W-1:0]         rms,
    output logic [swaf_pkg::AMP_W-1:0]         amplitude
);

    localparam int C_W    = $clog2(WINDOW);
    localparam int IDX_W  = C_W;
    localparam int DEPTH  = AXES * WINDOW;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ABS_W  = 16 + C_W;          // magnitude of the window sum
    localparam int SUM_W  = ABS_W + 1;         // signed window sum
    localparam int SQ_W   = 31 + C_W;          // window sum of squares
    localparam int PROD_W = 2 * ABS_W;         // N*S2 and S1^2
    localparam int MUL_W  = SQ_W + ABS_W;
    localparam int DEN    = WINDOW * (WINDOW - 1);
    localparam int DV_W   = $clog2(DEN + 1);
    localparam int AX_IW  = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int SW     = swaf_pkg::SAMPLE_W;
    localparam int DIF_W  = SW + 1;

    swaf_pkg::state_t state_reg, state_next;

    // input transaction
    logic [swaf_pkg::AXIS_W-1:0] ax_reg;
    logic signed [SW-1:0]        s_reg;
    logic                        bad_reg;
    logic [AX_IW-1:0]            ix;
    logic                        ax_ok;

    // per-axis running state
    logic [IDX_W-1:0]        pos_reg [AXES];
    logic signed [SUM_W-1:0] sum_reg [AXES];
    logic [SQ_W-1:0]         sq_reg  [AXES];

    // clearing pass and window scan
    logic [ADDR_W-1:0] clr_reg;
    logic              scan_act_reg;
    logic              rd_vld_reg;
    logic [IDX_W-1:0]  scan_idx_reg;
    logic signed [SW-1:0] mn_reg, mx_reg;
    logic              scan_busy;
    logic              scan_last;

    // ram port
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [SW-1:0]     mem_wdata;
    logic [SW-1:0]     mem_rdata;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] scan_addr;

    // arithmetic
    logic [DIF_W-1:0]  d_val, e_val, d_mag, e_mag;
    logic              neg_reg;
    logic [SUM_W-1:0]  sum_neg;
    logic [ABS_W-1:0]  abs_sum;
    logic [PROD_W-1:0] a_reg, b_reg;
    logic [PROD_W-1:0] num;
    logic [swaf_pkg::VAR_W-1:0] var_reg;
    logic [swaf_pkg::VAR_W-1:0] quo_sat;

    logic              mul_start, mul_done;
    logic [SQ_W-1:0]   mul_a;
    logic [ABS_W-1:0]  mul_b;
    logic [MUL_W-1:0]  mul_prod;
    logic [SQ_W-1:0]   delta;

    logic              div_start, div_done;
    logic [PROD_W-1:0] div_dvd;
    logic [DV_W-1:0]   div_dvs;
    logic [PROD_W-1:0] div_quo;

    // square root, two bits per step
    logic [swaf_pkg::VAR_W-1:0]   sv_reg;
    logic [17:0]                  srem_reg;
    logic [swaf_pkg::RMS_W-1:0]   root_reg;
    logic [swaf_pkg::SQRT_CNT_W-1:0] scnt_reg;
    logic [19:0]                  srem_sh;
    logic [19:0]                  strial;
    logic                         sge;
    logic                         sqrt_last;

    // output register
    logic                        out_valid_reg;
    logic [swaf_pkg::AXIS_W-1:0] axis_out_reg;
    logic [swaf_pkg::VAR_W-1:0]  variance_reg;
    logic [swaf_pkg::RMS_W-1:0]  rms_reg;
    logic [swaf_pkg::AMP_W-1:0]  amplitude_reg;
    logic                        out_load;

    assign ix    = ax_reg[AX_IW-1:0];
    assign ax_ok = ({1'b0, axis} < 3'(AXES));

    assign base      = ADDR_W'(ax_reg) * ADDR_W'(WINDOW);
    assign wr_addr   = base + ADDR_W'(pos_reg[ix]);
    assign scan_addr = base + ADDR_W'(scan_idx_reg);
    assign scan_busy = scan_act_reg | rd_vld_reg;
    assign scan_last = (scan_idx_reg == IDX_W'(WINDOW - 1));

    // sample minus oldest and sample plus oldest: their product is the change of S2
    assign d_val = {s_reg[SW-1], s_reg} - {mem_rdata[SW-1], mem_rdata};
    assign e_val = {s_reg[SW-1], s_reg} + {mem_rdata[SW-1], mem_rdata};
    assign d_mag = d_val[DIF_W-1] ? -d_val : d_val;
    assign e_mag = e_val[DIF_W-1] ? -e_val : e_val;

    assign sum_neg = -sum_reg[ix];
    assign abs_sum = sum_reg[ix][SUM_W-1] ? sum_neg[ABS_W-1:0] : sum_reg[ix][ABS_W-1:0];
    assign num     = (a_reg >= b_reg) ? (a_reg - b_reg) : '0;
    assign delta   = mul_prod[SQ_W-1:0];
    assign quo_sat = (|div_quo[PROD_W-1:swaf_pkg::VAR_W]) ? '1 : div_quo[swaf_pkg::VAR_W-1:0];

    assign srem_sh   = {srem_reg, sv_reg[swaf_pkg::VAR_W-1 -: 2]};
    assign strial    = {2'b00, root_reg, 2'b01};
    assign sge       = (srem_sh >= strial);
    assign sqrt_last = (scnt_reg == swaf_pkg::SQRT_CNT_W'(swaf_pkg::SQRT_STEPS - 1));

    assign out_load = (state_reg == swaf_pkg::ST_DONE) && !scan_busy &&
                      (!out_valid_reg || out_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            swaf_pkg::ST_CLEAR:
            begin
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = swaf_pkg::ST_IDLE;
                end
            end
            swaf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ax_ok ? swaf_pkg::ST_READ : swaf_pkg::ST_DONE;
                end
            end
            swaf_pkg::ST_READ:     state_next = swaf_pkg::ST_UPDATE;
            swaf_pkg::ST_UPDATE:   state_next = swaf_pkg::ST_WAIT_DE;
            swaf_pkg::ST_WAIT_DE:
            begin
                if (mul_done)
                begin
                    state_next = swaf_pkg::ST_APPLY;
                end
            end
            swaf_pkg::ST_APPLY:    state_next = swaf_pkg::ST_GO_NSQ;
            swaf_pkg::ST_GO_NSQ:   state_next = swaf_pkg::ST_WAIT_NSQ;
            swaf_pkg::ST_WAIT_NSQ:
            begin
                if (mul_done)
                begin
                    state_next = swaf_pkg::ST_GO_SUM2;
                end
            end
            swaf_pkg::ST_GO_SUM2:  state_next = swaf_pkg::ST_WAIT_SUM2;
            swaf_pkg::ST_WAIT_SUM2:
            begin
                if (mul_done)
                begin
                    state_next = swaf_pkg::ST_GO_VAR;
                end
            end
            swaf_pkg::ST_GO_VAR:   state_next = swaf_pkg::ST_WAIT_VAR;
            swaf_pkg::ST_WAIT_VAR:
            begin
                if (div_done)
                begin
                    state_next = swaf_pkg::ST_GO_MSQ;
                end
            end
            swaf_pkg::ST_GO_MSQ:   state_next = swaf_pkg::ST_WAIT_MSQ;
            swaf_pkg::ST_WAIT_MSQ:
            begin
                if (div_done)
                begin
                    state_next = swaf_pkg::ST_SQRT;
                end
            end
            swaf_pkg::ST_SQRT:
            begin
                if (sqrt_last)
                begin
                    state_next = swaf_pkg::ST_DONE;
                end
            end
            swaf_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = swaf_pkg::ST_IDLE;
                end
            end
            default:               state_next = swaf_pkg::ST_IDLE;
        endcase
    end

    // state outputs: handshake, ram port, unit starts and operands
    always_comb
    begin
        in_ready  = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = scan_addr;
        mem_wdata = s_reg;
        mul_start = 1'b0;
        mul_a     = {{(SQ_W-ABS_W){1'b0}}, abs_sum};
        mul_b     = abs_sum;
        div_start = 1'b0;
        div_dvd   = num;
        div_dvs   = DV_W'(DEN);
        case (state_reg)
            swaf_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = '0;
            end
            swaf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            swaf_pkg::ST_READ:
            begin
                mem_addr = wr_addr;
            end
            swaf_pkg::ST_UPDATE:
            begin
                mem_we    = 1'b1;
                mem_addr  = wr_addr;
                mul_start = 1'b1;
                mul_a     = {{(SQ_W-DIF_W){1'b0}}, d_mag};
                mul_b     = {{(ABS_W-DIF_W){1'b0}}, e_mag};
            end
            swaf_pkg::ST_GO_NSQ:
            begin
                mul_start = 1'b1;
                mul_a     = sq_reg[ix];
                mul_b     = ABS_W'(WINDOW);
            end
            swaf_pkg::ST_GO_SUM2:
            begin
                mul_start = 1'b1;
            end
            swaf_pkg::ST_GO_VAR:
            begin
                div_start = 1'b1;
            end
            swaf_pkg::ST_GO_MSQ:
            begin
                div_start = 1'b1;
                div_dvd   = {{(PROD_W-SQ_W){1'b0}}, sq_reg[ix]};
                div_dvs   = DV_W'(WINDOW);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swaf_pkg::ST_CLEAR;
            clr_reg       <= '0;
            scan_act_reg  <= 1'b0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < AXES; i++)
            begin
                pos_reg[i] <= '0;
                sum_reg[i] <= '0;
                sq_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == swaf_pkg::ST_CLEAR)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            if (state_reg == swaf_pkg::ST_UPDATE)
            begin
                scan_act_reg <= 1'b1;
                pos_reg[ix]  <= (pos_reg[ix] == IDX_W'(WINDOW - 1)) ? '0
                                : pos_reg[ix] + IDX_W'(1);
                sum_reg[ix]  <= sum_reg[ix] + {{(SUM_W-DIF_W){d_val[DIF_W-1]}}, d_val};
            end
            else if (scan_act_reg && scan_last)
            begin
                scan_act_reg <= 1'b0;
            end
            rd_vld_reg <= scan_act_reg;
            if (state_reg == swaf_pkg::ST_APPLY)
            begin
                sq_reg[ix] <= neg_reg ? (sq_reg[ix] - delta) : (sq_reg[ix] + delta);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ax_reg  <= axis;
            s_reg   <= sample;
            bad_reg <= !ax_ok;
        end
        if (state_reg == swaf_pkg::ST_UPDATE)
        begin
            neg_reg      <= d_val[DIF_W-1] ^ e_val[DIF_W-1];
            scan_idx_reg <= '0;
            mn_reg       <= {1'b0, {(SW-1){1'b1}}};
            mx_reg       <= {1'b1, {(SW-1){1'b0}}};
        end
        else
        begin
            if (scan_act_reg)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end
            if (rd_vld_reg)
            begin
                if ($signed(mem_rdata) < mn_reg)
                begin
                    mn_reg <= $signed(mem_rdata);
                end
                if ($signed(mem_rdata) > mx_reg)
                begin
                    mx_reg <= $signed(mem_rdata);
                end
            end
        end
        if (state_reg == swaf_pkg::ST_WAIT_NSQ && mul_done)
        begin
            a_reg <= mul_prod[PROD_W-1:0];
        end
        if (state_reg == swaf_pkg::ST_WAIT_SUM2 && mul_done)
        begin
            b_reg <= mul_prod[PROD_W-1:0];
        end
        if (state_reg == swaf_pkg::ST_WAIT_VAR && div_done)
        begin
            var_reg <= quo_sat;
        end
        if (state_reg == swaf_pkg::ST_WAIT_MSQ && div_done)
        begin
            sv_reg   <= quo_sat;
            srem_reg <= '0;
            root_reg <= '0;
            scnt_reg <= '0;
        end
        if (state_reg == swaf_pkg::ST_SQRT)
        begin
            sv_reg   <= {sv_reg[swaf_pkg::VAR_W-3:0], 2'b00};
            srem_reg <= sge ? 18'(srem_sh - strial) : srem_sh[17:0];
            root_reg <= {root_reg[swaf_pkg::RMS_W-2:0], sge};
            scnt_reg <= scnt_reg + swaf_pkg::SQRT_CNT_W'(1);
        end
        if (out_load)
        begin
            axis_out_reg  <= ax_reg;
            variance_reg  <= bad_reg ? '0 : var_reg;
            rms_reg       <= bad_reg ? '0 : root_reg;
            amplitude_reg <= bad_reg ? '0 : (mx_reg - mn_reg);
        end
    end

    swaf_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_window_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    swaf_mul #(
        .A_W (SQ_W),
        .B_W (ABS_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    swaf_div #(
        .DW (PROD_W),
        .VW (DV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign out_valid = out_valid_reg;
    assign axis_out  = axis_out_reg;
    assign variance  = variance_reg;
    assign rms       = rms_reg;
    assign amplitude = amplitude_reg;

    // checks
    `SWAF_ASSERT_IMP(a_ready_only_idle, in_ready, state_reg == swaf_pkg::ST_IDLE)
    `SWAF_ASSERT_IMP(a_no_scan_in_idle, state_reg == swaf_pkg::ST_IDLE, !scan_busy)
    `SWAF_ASSERT_NXT(a_scan_starts, state_reg == swaf_pkg::ST_UPDATE, scan_act_reg)
    `SWAF_ASSERT_IMP(a_rms_range, out_valid_reg, rms_reg <= 16'h8000)

endmodule

### test/testbench.sv
// self-checking testbench for the sliding window accelerometer feature block
`timescale 1ns / 1ps
module testbench;

    localparam int WINDOW     = 150;
    localparam int AXES       = 3;
    localparam int RANDOM_CNT = 1520;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_AT    = 170;
    localparam int HOLD_LEN   = 3000;

    localparam int AXIS_W   = swaf_pkg::AXIS_W;
    localparam int SAMPLE_W = swaf_pkg::SAMPLE_W;
    localparam int VAR_W    = swaf_pkg::VAR_W;
    localparam int RMS_W    = swaf_pkg::RMS_W;
    localparam int AMP_W    = swaf_pkg::AMP_W;

    typedef struct packed {
        logic [AXIS_W-1:0]          axis;
        logic signed [SAMPLE_W-1:0] sample;
    } sample_txn_t;

    typedef struct packed {
        logic [AXIS_W-1:0] axis;
        logic [VAR_W-1:0]  variance;
        logic [RMS_W-1:0]  rms;
        logic [AMP_W-1:0]  amplitude;
    } features_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [AXIS_W-1:0] axis = '0;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [AXIS_W-1:0] axis_out;
    logic [VAR_W-1:0] variance;
    logic [RMS_W-1:0] rms;
    logic [AMP_W-1:0] amplitude;

    sliding_window_accel_features #(.WINDOW(WINDOW), .AXES(AXES)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .axis(axis), .sample(sample),
        .out_valid(out_valid), .out_ready(out_ready), .axis_out(axis_out),
        .variance(variance), .rms(rms), .amplitude(amplitude)
    );

    always #10 clk = ~clk;

    // predictor state: per-axis window, oldest slot and exact running sums
    logic signed [SAMPLE_W-1:0] win_mem [AXES][WINDOW];
    int unsigned  oldest_slot [AXES];
    longint       run_sum [AXES];
    longint       run_sum_sq [AXES];

    sample_txn_t  pending_samples[$];
    features_t    expected_features[$];
    int           error_count = 0;
    int           sent_count = 0;
    int           issued_count = 0;
    int           result_count = 0;
    int           bad_axis_count = 0;
    bit           stimulus_done = 1'b0;
    bit           sender_paused = 1'b0;
    int           burst_left = 0;
    int           gap_left = 0;
    int           hold_left = 0;
    bit           hold_done = 1'b0;

    // bit-serial integer square root, two bits of radicand per step
    function automatic logic [RMS_W-1:0] int_sqrt(input logic [31:0] radicand);
        logic [31:0] remain;
        logic [31:0] root;
        logic [31:0] trial;
        remain = 0;
        root = 0;
        for (int k = 0; k < 16; k++) begin
            remain = (remain << 2) | (radicand >> 30);
            radicand = radicand << 2;
            root = root << 1;
            trial = (root << 1) | 32'd1;
            if (trial <= remain) begin
                remain = remain - trial;
                root = root | 32'd1;
            end
        end
        return root[RMS_W-1:0];
    endfunction

    // apply one sample to the window and work out the feature set it returns
    function automatic features_t window_features(input sample_txn_t txn);
        features_t f;
        int ax;
        int slot;
        longint old_val;
        longint new_val;
        longint abs_sum;
        longint numer;
        longint quot;
        longint mean_sq;
        int lo;
        int hi;
        f.axis = txn.axis;
        f.variance = '0;
        f.rms = '0;
        f.amplitude = '0;
        ax = txn.axis;
        if (ax >= AXES)
            return f;
        slot = oldest_slot[ax];
        old_val = win_mem[ax][slot];
        new_val = txn.sample;
        win_mem[ax][slot] = txn.sample;
        run_sum[ax] += new_val - old_val;
        run_sum_sq[ax] += new_val * new_val - old_val * old_val;
        oldest_slot[ax] = (slot == WINDOW - 1) ? 0 : slot + 1;
        abs_sum = run_sum[ax] < 0 ? -run_sum[ax] : run_sum[ax];
        numer = WINDOW * run_sum_sq[ax] - abs_sum * abs_sum;
        if (numer < 0)
            numer = 0;
        quot = numer / (WINDOW * (WINDOW - 1));
        f.variance = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
        mean_sq = run_sum_sq[ax] / WINDOW;
        if (mean_sq > 64'hFFFF_FFFF)
            mean_sq = 64'hFFFF_FFFF;
        f.rms = int_sqrt(mean_sq[31:0]);
        lo = win_mem[ax][0];
        hi = lo;
        for (int i = 1; i < WINDOW; i++) begin
            if (win_mem[ax][i] > hi)
                hi = win_mem[ax][i];
            if (win_mem[ax][i] < lo)
                lo = win_mem[ax][i];
        end
        f.amplitude = AMP_W'(hi - lo);
        return f;
    endfunction

    function automatic sample_txn_t make_sample(input int ax, input int val);
        sample_txn_t t;
        t.axis = AXIS_W'(ax);
        t.sample = SAMPLE_W'(val);
        return t;
    endfunction

    // random samples with a mix of full scale, small, clustered and uniform values, some on an out of range axis
    function automatic sample_txn_t random_sample();
        int ax;
        int val;
        ax = ($urandom_range(0, 39) == 0) ? 3 : $urandom_range(0, AXES - 1);
        case ($urandom_range(0, 5))
            0: val = $urandom_range(0, 1) ? 32767 : -32768;
            1: val = $signed($urandom_range(0, 15)) - 8;
            2: val = $signed($urandom_range(0, 2000)) + 15000;
            default: val = $signed($urandom_range(0, 65535)) - 32768;
        endcase
        return make_sample(ax, val);
    endfunction

    initial begin
        for (int a = 0; a < AXES; a++) begin
            for (int i = 0; i < WINDOW; i++)
                win_mem[a][i] = '0;
            oldest_slot[a] = 0;
            run_sum[a] = 0;
            run_sum_sq[a] = 0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, sign bits, every axis and an out of range axis
        pending_samples.push_back(make_sample(0, 32767));
        pending_samples.push_back(make_sample(0, -32768));
        pending_samples.push_back(make_sample(1, -32768));
        pending_samples.push_back(make_sample(1, -32768));
        pending_samples.push_back(make_sample(2, 0));
        pending_samples.push_back(make_sample(2, -1));
        pending_samples.push_back(make_sample(2, 1));
        pending_samples.push_back(make_sample(3, 12345));
        pending_samples.push_back(make_sample(3, -32768));
        pending_samples.push_back(make_sample(0, 21845));
        pending_samples.push_back(make_sample(1, -21846));
        pending_samples.push_back(make_sample(2, 32767));
        while (pending_samples.size() != 0)
            @(posedge clk);

        // wait for the block to drain, then keep it busy for a full wrap
        sender_paused = 1'b1;
        while (expected_features.size() != 0)
            @(posedge clk);
        sender_paused = 1'b0;

        // fill axis 0 past its window edge with full-scale values
        for (int i = 0; i < WINDOW + 5; i++)
            pending_samples.push_back(make_sample(0, (i % 2) ? 32767 : -32768));

        // the receiver starts its long stall soon after the wrap, sender keeps offering
        for (int i = 0; i < 40; i++)
            pending_samples.push_back(random_sample());

        for (int i = 0; i < RANDOM_CNT - 200; i++)
            pending_samples.push_back(random_sample());
        while (pending_samples.size() != 0)
            @(posedge clk);
        stimulus_done = 1'b1;
    end

    // driver: bursts of random length separated by random gaps
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_valid && issued_count != sent_count) begin
                // hold the transaction until accepted
            end else begin
                if (in_valid) begin
                    // accepted at the last rising edge
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
                    end
                end
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (!sender_paused && pending_samples.size() != 0) begin
                    axis <= pending_samples[0].axis;
                    sample <= pending_samples[0].sample;
                    in_valid <= 1'b1;
                    issued_count++;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // acceptance of input transactions
    always @(posedge clk) begin
        if (in_valid && in_ready) begin
            sample_txn_t t;
            t = pending_samples.pop_front();
            expected_features.push_back(window_features(t));
            sent_count++;
            if (t.axis >= AXES)
                bad_axis_count++;
        end
    end

    // receiver stall pattern: one long hold, then long ready windows and short stalls
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (!hold_done && sent_count >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
            out_ready <= 1'b0;
        end else if (result_count % 200 < 100) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // monitor: compare each output transaction with the oldest expectation
    always @(posedge clk) begin
        if (out_valid && out_ready) begin
            features_t exp_f;
            result_count++;
            if (expected_features.size() == 0) begin
                $error("unexpected output transaction, axis_out %0d", axis_out);
                error_count++;
            end else begin
                exp_f = expected_features.pop_front();
                if (axis_out !== exp_f.axis) begin
                    $error("axis_out expected %0d actual %0d", exp_f.axis, axis_out);
                    error_count++;
                end
                if (variance !== exp_f.variance) begin
                    $error("variance expected %0d actual %0d", exp_f.variance, variance);
                    error_count++;
                end
                if (rms !== exp_f.rms) begin
                    $error("rms expected %0d actual %0d", exp_f.rms, rms);
                    error_count++;
                end
                if (amplitude !== exp_f.amplitude) begin
                    $error("amplitude expected %0d actual %0d",
                           exp_f.amplitude, amplitude);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction, plus the end of run
    initial begin
        int quiet;
        quiet = 0;
        while (!(stimulus_done && expected_features.size() == 0) && quiet < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        if (quiet >= IDLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_features.size());
            $display("Mismatches found");
            $finish;
        end else begin
            repeat (300) @(posedge clk);
            $display("ran %0d samples (%0d with an out of range axis), %0d results",
                     sent_count, bad_axis_count, result_count);
            $display("full-scale window wrap, long receiver stall and drain pause covered");
            if (error_count == 0 && expected_features.size() == 0)
                $display("No mismatches found");
            else
                $display("Mismatches found");
            $finish;
        end
    end

endmodule
